// ===== rtl/dbs_pkg.sv =====
// shared types and constants for the debounced button stepper
`timescale 1ns / 1ps

package dbs_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int MAX_STEPS   = 16;
  // index output is four bits wide, so no more than sixteen steps are reachable
  localparam int STEP_CAP    = (MAX_STEPS < 16) ? MAX_STEPS : 16;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  // button order inside every four-bit vector
  localparam int BTN_RIGHT = 0;
  localparam int BTN_LEFT  = 1;
  localparam int BTN_INC   = 2;
  localparam int BTN_DEC   = 3;

  localparam logic [3:0] ACTIVE_LEVELS_RST = 4'd0;
  localparam logic [7:0] SETTLE_TICKS_RST  = 8'd40;
  localparam logic [4:0] STEP_COUNT_RST    = 5'd16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ACTIVE_LEVELS = 2'd0,
    CFG_SETTLE_TICKS  = 2'd1,
    CFG_STEP_COUNT    = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    BTN_UP      = 2'd0,
    BTN_FALLING = 2'd1,
    BTN_DOWN    = 2'd2,
    BTN_RISING  = 2'd3
  } btn_state_t;

  // per button status handed to the top level
  typedef struct packed {
    logic fire;     // fresh press resolved this word
    logic pressed;  // debounced level, from the state register
  } btn_stat_t;

endpackage

// ===== rtl/dbs_in_if.sv =====
// input channel: one tick word with the raw button levels
`timescale 1ns / 1ps

interface dbs_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

// ===== rtl/dbs_out_if.sv =====
// output channel: debounced flags, direction and step index
`timescale 1ns / 1ps

interface dbs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pressed;
  logic       direction;
  logic [3:0] step_index;

  modport source (output valid, output pressed, output direction, output step_index,
                  input ready);
  modport sink   (input valid, input pressed, input direction, input step_index,
                  output ready);
endinterface

// ===== rtl/dbs_button.sv =====
// debounce machine and settle counter for one button
`timescale 1ns / 1ps

module dbs_button
  import dbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      level_pressed,
  input  logic [7:0] settle_ticks,
  output btn_stat_t stat
);

  btn_state_t state, state_next;
  logic [7:0] settle_cnt, settle_cnt_next;
  logic [7:0] cnt_inc;
  logic [7:0] wait_ticks;
  logic       fire;

  // zero settle behaves as one
  assign wait_ticks = (settle_ticks == 8'd0) ? 8'd1 : settle_ticks;
  assign cnt_inc    = (settle_cnt == 8'hff) ? settle_cnt : settle_cnt + 8'd1;

  always_comb begin
    state_next      = state;
    settle_cnt_next = settle_cnt;
    fire            = 1'b0;
    unique case (state)
      BTN_UP: begin
        if (level_pressed) begin
          state_next      = BTN_FALLING;
          settle_cnt_next = 8'd0;
        end
      end
      BTN_DOWN: begin
        if (!level_pressed) begin
          state_next      = BTN_RISING;
          settle_cnt_next = 8'd0;
        end
      end
      BTN_FALLING, BTN_RISING: begin
        settle_cnt_next = cnt_inc;
        if (cnt_inc >= wait_ticks) begin
          if (level_pressed) begin
            // bounce on release goes back to down without firing
            fire       = (state == BTN_FALLING);
            state_next = BTN_DOWN;
          end else begin
            state_next = BTN_UP;
          end
        end
      end
      default: state_next = BTN_UP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BTN_UP;
      settle_cnt <= 8'd0;
    end else if (en) begin
      state      <= state_next;
      settle_cnt <= settle_cnt_next;
    end
  end

  assign stat.fire    = en & fire;
  assign stat.pressed = (state == BTN_DOWN) || (state == BTN_RISING);

endmodule

// ===== rtl/dbs_stepper.sv =====
// direction flag and saturating step index driven by button presses
`timescale 1ns / 1ps

module dbs_stepper
  import dbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] fire,
  input  logic [4:0] step_count,
  output logic       direction,
  output logic [3:0] step_index
);

  logic       direction_next;
  logic [3:0] step_index_next;
  logic [4:0] limit;
  logic [3:0] top;
  logic [4:0] inc_val;
  logic [3:0] after_inc;

  always_comb begin
    if (step_count == 5'd0) begin
      limit = 5'd1;
    end else if (step_count > 5'(STEP_CAP)) begin
      limit = 5'(STEP_CAP);
    end else begin
      limit = step_count;
    end
  end

  assign top     = 4'(limit - 5'd1);
  assign inc_val = {1'b0, step_index} + 5'd1;

  always_comb begin
    // left is applied after right, so it wins
    direction_next = direction;
    if (fire[BTN_RIGHT]) direction_next = 1'b1;
    if (fire[BTN_LEFT])  direction_next = 1'b0;

    after_inc = step_index;
    if (fire[BTN_INC]) begin
      after_inc = (inc_val > {1'b0, top}) ? top : inc_val[3:0];
    end
    step_index_next = after_inc;
    if (fire[BTN_DEC] && (after_inc != 4'd0)) begin
      step_index_next = after_inc - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      step_index <= 4'd0;
    end else begin
      direction  <= direction_next;
      step_index <= step_index_next;
    end
  end

endmodule

// ===== rtl/debounced_button_stepper.sv =====
// top level: four button debouncers with direction and step index control
//
// in_ch carries one word per millisecond tick holding the raw levels of the
// right, left, increase and decrease buttons (bits 0 to 3). each word
// produces exactly one word on out_ch: the debounced pressed flags, the
// direction flag and the step index, all as they stand after that tick.
// a word taken at one edge sits in the input register, is processed at the
// next edge where the output is free, and shows on out_ch from then on.
// while out_ch is not stalled, throughput is one word per cycle; the state
// registers double as the output register, so the whole update is one
// pass through the debounce and stepper logic.
// when out_ch stalls, the held result keeps the state frozen; the input
// register still takes one further word if it is empty, then in_ch.ready
// drops until the result is taken.
// reset clears all machines to up, counters, direction and index to zero,
// and loads the configuration defaults (active level low for all buttons,
// 40 tick settle, 16 steps).
// configuration: cfg_we with cfg_index 0 active levels, 1 settle ticks,
// 2 step count; index 3 is ignored. write only while the block is idle.
`timescale 1ns / 1ps

module debounced_button_stepper
  import dbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  dbs_in_if.sink                 in_ch,
  dbs_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [3:0] active_levels;
  logic [7:0] settle_ticks;
  logic [4:0] step_count;

  // input register
  logic       in_vld;
  logic [3:0] raw_q;

  // result handshake
  logic       out_vld;
  logic       advance;
  logic [3:0] match;
  logic [3:0] fire;
  logic [3:0] pressed;
  btn_stat_t  stat [NUM_BUTTONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels <= ACTIVE_LEVELS_RST;
      settle_ticks  <= SETTLE_TICKS_RST;
      step_count    <= STEP_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ACTIVE_LEVELS: active_levels <= cfg_data[3:0];
        CFG_SETTLE_TICKS:  settle_ticks  <= cfg_data[7:0];
        CFG_STEP_COUNT:    step_count    <= cfg_data[4:0];
        CFG_UNUSED:        ;
        default:           ;
      endcase
    end
  end

  // the held word moves into the state once the result slot is free
  assign advance     = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      raw_q <= in_ch.raw_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  // a button reads as pressed when its pin matches its active level
  assign match = ~(raw_q ^ active_levels);

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    dbs_button u_btn (
      .clk           (clk),
      .rst           (rst),
      .en            (advance),
      .level_pressed (match[b]),
      .settle_ticks  (settle_ticks),
      .stat          (stat[b])
    );
    assign fire[b]    = stat[b].fire;
    assign pressed[b] = stat[b].pressed;
  end

  // fire is gated by advance inside each button, so the stepper only moves then
  dbs_stepper u_stepper (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .step_count (step_count),
    .direction  (out_ch.direction),
    .step_index (out_ch.step_index)
  );

  assign out_ch.valid   = out_vld;
  assign out_ch.pressed = pressed;

  // state only moves when a word is processed
  a_state_frozen: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(out_ch.pressed) && $stable(out_ch.step_index)
      && $stable(out_ch.direction))
    else $error("state changed without a word being processed");

  // a blocked input means the input register holds a word
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> in_vld)
    else $error("input stalled with empty input register");

  // direction only changes after a right or left press resolves
  a_dir_cause: assert property (@(posedge clk) disable iff (rst)
    !fire[BTN_RIGHT] && !fire[BTN_LEFT] |=> $stable(out_ch.direction))
    else $error("direction changed without a right or left press");

endmodule
